// ===== hdl/pbe_pkg.sv =====
// Shared types and constants for the run-length row encoder.
`timescale 1ns / 1ps

package pbe_pkg;

  // Result width in encoded bytes, and the byte lanes that the output word shows.
  localparam int BYTES_PER_RESULT = 4;
  localparam int OUT_BYTES        = 4;

  // Literal store geometry.
  localparam int LIT_DEPTH = 128;
  localparam int LIT_AW    = 7;

  localparam logic [7:0] LIT_MAX    = 8'd128;
  localparam logic [7:0] RUN_MIN    = 8'd3;
  localparam logic [8:0] TOKEN_BASE = 9'd257;
  localparam logic [7:0] END_MARKER = 8'd128;

  // Events that the sequencer hands to the packer.
  typedef enum logic [1:0] {
    EV_BYTE,
    EV_CLOSE,
    EV_MARK
  } ev_kind_t;

  typedef struct packed {
    logic       valid;
    ev_kind_t   kind;
    logic [7:0] data;
    logic       row;
  } pbe_ev_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_RUN_CLOSE,
    S_PUSH,
    S_LIT_HDR,
    S_LIT_DATA,
    S_RUN_TOK,
    S_RUN_VAL,
    S_WORD_CLOSE,
    S_MARK
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_SPLIT,
    PH_ADD,
    PH_ROW,
    PH_FLUSH
  } phase_t;

endpackage

// ===== hdl/pbe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module pbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/pbe_seq.sv =====
// Token sequencer: run tracking, literal store writes and the byte-by-byte token walk.
`timescale 1ns / 1ps

module pbe_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output pbe_pkg::pbe_ev_t            ev,
  input  logic                        ev_ready,
  output logic                        lit_wr_en,
  output logic [pbe_pkg::LIT_AW-1:0]  lit_wr_addr,
  output logic [7:0]                  lit_wr_data,
  output logic [pbe_pkg::LIT_AW-1:0]  lit_rd_addr,
  input  logic [7:0]                  lit_rd_data
);

  pbe_pkg::seq_state_t state_r, state_nxt;
  pbe_pkg::seq_state_t lit_ret_r, lit_ret_nxt;
  pbe_pkg::phase_t     phase_r, phase_nxt;

  logic [7:0]                 fill_r, fill_nxt;
  logic [7:0]                 run_len_r, run_len_nxt;
  logic [7:0]                 run_val_r, run_val_nxt;
  logic [pbe_pkg::LIT_AW-1:0] idx_r, idx_nxt;
  logic                       mode_r, mode_nxt;
  logic                       last_r, last_nxt;
  logic [7:0]                 byte_r, byte_nxt;

  logic [7:0] fill_inc;
  logic [7:0] fill_dec;
  logic [8:0] token_wide;

  assign fill_inc   = fill_r + 8'd1;
  assign fill_dec   = fill_r - 8'd1;
  assign token_wide = pbe_pkg::TOKEN_BASE - {1'b0, run_len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pbe_pkg::S_IDLE;
      lit_ret_r <= pbe_pkg::S_IDLE;
      phase_r   <= pbe_pkg::PH_SPLIT;
      fill_r    <= '0;
      run_len_r <= '0;
      run_val_r <= '0;
      idx_r     <= '0;
      mode_r    <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lit_ret_r <= lit_ret_nxt;
      phase_r   <= phase_nxt;
      fill_r    <= fill_nxt;
      run_len_r <= run_len_nxt;
      run_val_r <= run_val_nxt;
      idx_r     <= idx_nxt;
      mode_r    <= mode_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    lit_ret_nxt = lit_ret_r;
    phase_nxt   = phase_r;
    fill_nxt    = fill_r;
    run_len_nxt = run_len_r;
    run_val_nxt = run_val_r;
    idx_nxt     = idx_r;
    mode_nxt    = mode_r;
    last_nxt    = last_r;
    byte_nxt    = byte_r;

    in_ready    = 1'b0;
    ev.valid    = 1'b0;
    ev.kind     = pbe_pkg::EV_BYTE;
    ev.data     = 8'd0;
    ev.row      = 1'b0;
    lit_wr_en   = 1'b0;

    case (state_r)
      pbe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt  = in_mode;
          last_nxt  = in_last;
          byte_nxt  = in_byte;
          phase_nxt = pbe_pkg::PH_SPLIT;
          state_nxt = pbe_pkg::S_DECIDE;
        end
      end

      pbe_pkg::S_DECIDE: begin
        case (phase_r)
          pbe_pkg::PH_SPLIT: begin
            if (mode_r) begin
              phase_nxt = pbe_pkg::PH_FLUSH;
              if (run_len_r != 8'd0) begin
                state_nxt = pbe_pkg::S_RUN_CLOSE;
              end
            end else begin
              phase_nxt = pbe_pkg::PH_ADD;
              if (run_len_r != 8'd0 && byte_r != run_val_r) begin
                state_nxt = pbe_pkg::S_RUN_CLOSE;
              end
            end
          end
          pbe_pkg::PH_ADD: begin
            run_val_nxt = byte_r;
            run_len_nxt = run_len_r + 8'd1;
            phase_nxt   = pbe_pkg::PH_ROW;
            if (run_len_nxt == pbe_pkg::LIT_MAX) begin
              state_nxt = pbe_pkg::S_RUN_CLOSE;
            end
          end
          pbe_pkg::PH_ROW: begin
            if (last_r) begin
              phase_nxt = pbe_pkg::PH_FLUSH;
              if (run_len_r != 8'd0) begin
                state_nxt = pbe_pkg::S_RUN_CLOSE;
              end
            end else begin
              state_nxt = pbe_pkg::S_WORD_CLOSE;
            end
          end
          pbe_pkg::PH_FLUSH: begin
            if (fill_r != 8'd0) begin
              lit_ret_nxt = pbe_pkg::S_WORD_CLOSE;
              state_nxt   = pbe_pkg::S_LIT_HDR;
            end else begin
              state_nxt = pbe_pkg::S_WORD_CLOSE;
            end
          end
          default: begin
            state_nxt = pbe_pkg::S_WORD_CLOSE;
          end
        endcase
      end

      // A long run flushes the pending literal and becomes a token; a short one
      // is moved byte by byte into the literal.
      pbe_pkg::S_RUN_CLOSE: begin
        if (run_len_r >= pbe_pkg::RUN_MIN) begin
          if (fill_r != 8'd0) begin
            lit_ret_nxt = pbe_pkg::S_RUN_TOK;
            state_nxt   = pbe_pkg::S_LIT_HDR;
          end else begin
            state_nxt = pbe_pkg::S_RUN_TOK;
          end
        end else begin
          state_nxt = pbe_pkg::S_PUSH;
        end
      end

      pbe_pkg::S_PUSH: begin
        if (run_len_r == 8'd0) begin
          state_nxt = pbe_pkg::S_DECIDE;
        end else begin
          lit_wr_en   = 1'b1;
          fill_nxt    = fill_inc;
          run_len_nxt = run_len_r - 8'd1;
          if (fill_inc == pbe_pkg::LIT_MAX) begin
            lit_ret_nxt = pbe_pkg::S_PUSH;
            state_nxt   = pbe_pkg::S_LIT_HDR;
          end
        end
      end

      pbe_pkg::S_LIT_HDR: begin
        ev.valid = 1'b1;
        ev.data  = fill_dec;
        idx_nxt  = '0;
        if (ev_ready) begin
          state_nxt = pbe_pkg::S_LIT_DATA;
        end
      end

      pbe_pkg::S_LIT_DATA: begin
        ev.valid = 1'b1;
        ev.data  = lit_rd_data;
        if (ev_ready) begin
          if (idx_r == pbe_pkg::LIT_AW'(fill_dec)) begin
            idx_nxt   = '0;
            fill_nxt  = '0;
            state_nxt = lit_ret_r;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      pbe_pkg::S_RUN_TOK: begin
        ev.valid = 1'b1;
        ev.data  = token_wide[7:0];
        if (ev_ready) begin
          state_nxt = pbe_pkg::S_RUN_VAL;
        end
      end

      pbe_pkg::S_RUN_VAL: begin
        ev.valid = 1'b1;
        ev.data  = run_val_r;
        if (ev_ready) begin
          run_len_nxt = '0;
          state_nxt   = pbe_pkg::S_DECIDE;
        end
      end

      pbe_pkg::S_WORD_CLOSE: begin
        ev.valid = 1'b1;
        ev.kind  = pbe_pkg::EV_CLOSE;
        ev.row   = last_r & ~mode_r;
        if (ev_ready) begin
          state_nxt = mode_r ? pbe_pkg::S_MARK : pbe_pkg::S_IDLE;
        end
      end

      pbe_pkg::S_MARK: begin
        ev.valid = 1'b1;
        ev.kind  = pbe_pkg::EV_MARK;
        ev.data  = pbe_pkg::END_MARKER;
        if (ev_ready) begin
          state_nxt = pbe_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pbe_pkg::S_IDLE;
      end
    endcase
  end

  // Reads always target the byte that the walk presents next cycle, so the
  // registered read data lines up with idx_r in the dump state. Writes only
  // happen in the push state, before any dump reads the same entry.
  assign lit_rd_addr = idx_nxt;
  assign lit_wr_addr = fill_r[pbe_pkg::LIT_AW-1:0];
  assign lit_wr_data = run_val_r;

  a_idle_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pbe_pkg::S_IDLE |-> fill_r < pbe_pkg::LIT_MAX && run_len_r < pbe_pkg::LIT_MAX)
    else $error("literal fill or run length out of range between items");

  a_idx_parked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != pbe_pkg::S_LIT_DATA |-> idx_r == '0)
    else $error("literal index not parked outside the dump");

  a_tok_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pbe_pkg::S_RUN_TOK |-> run_len_r >= pbe_pkg::RUN_MIN && fill_r == 8'd0)
    else $error("run token for a short run or ahead of a pending literal");

endmodule

// ===== hdl/pbe_pack.sv =====
// Byte packer: gathers token bytes into result words and holds the output register.
`timescale 1ns / 1ps

module pbe_pack #(
  parameter int BYTES_PER_RESULT = pbe_pkg::BYTES_PER_RESULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pbe_pkg::pbe_ev_t ev,
  output logic             ev_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_packed,
  output logic [2:0]       out_count,
  output logic             out_row,
  output logic             out_end,
  output logic [31:0]      out_total
);

  localparam int CNT_W = $clog2(BYTES_PER_RESULT + 1);

  logic [7:0]       acc_r [BYTES_PER_RESULT];
  logic [7:0]       acc_nxt [BYTES_PER_RESULT];
  logic [7:0]       word [BYTES_PER_RESULT];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      total_r, total_nxt, total_inc;

  logic        oval_r, oval_nxt;
  logic [31:0] opk_r, opk_nxt;
  logic [2:0]  ocnt_r, ocnt_nxt;
  logic        orow_r, orow_nxt;
  logic        oend_r, oend_nxt;
  logic [31:0] otot_r, otot_nxt;

  logic [31:0] word_flat;
  logic        full;
  logic        out_free;
  logic        fire;

  assign full      = (cnt_r == CNT_W'(BYTES_PER_RESULT));
  assign out_free  = !oval_r || out_ready;
  assign total_inc = (total_r == 32'hFFFF_FFFF) ? total_r : total_r + 32'd1;

  // Bytes beyond the fill count read as zero.
  always_comb begin
    for (int k = 0; k < BYTES_PER_RESULT; k++) begin
      word[k] = (CNT_W'(k) < cnt_r) ? acc_r[k] : 8'd0;
    end
  end

  for (genvar g = 0; g < pbe_pkg::OUT_BYTES; g++) begin : g_lane
    if (g < BYTES_PER_RESULT) begin : g_used
      assign word_flat[8*g +: 8] = word[g];
    end else begin : g_pad
      assign word_flat[8*g +: 8] = 8'd0;
    end
  end

  always_comb begin
    case (ev.kind)
      pbe_pkg::EV_BYTE:  ev_ready = !full || out_free;
      pbe_pkg::EV_CLOSE: ev_ready = (cnt_r == '0) || out_free;
      pbe_pkg::EV_MARK:  ev_ready = out_free;
      default:           ev_ready = 1'b1;
    endcase
  end

  assign fire = ev.valid && ev_ready;

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    oval_nxt  = oval_r && !out_ready;
    opk_nxt   = opk_r;
    ocnt_nxt  = ocnt_r;
    orow_nxt  = orow_r;
    oend_nxt  = oend_r;
    otot_nxt  = otot_r;

    if (fire) begin
      case (ev.kind)
        pbe_pkg::EV_BYTE: begin
          total_nxt = total_inc;
          if (full) begin
            // A full word leaves once another byte shows it is not the last, or on the close.
            oval_nxt   = 1'b1;
            opk_nxt    = word_flat;
            ocnt_nxt   = 3'(cnt_r);
            orow_nxt   = 1'b0;
            oend_nxt   = 1'b0;
            otot_nxt   = '0;
            acc_nxt[0] = ev.data;
            cnt_nxt    = CNT_W'(1);
          end else begin
            for (int k = 0; k < BYTES_PER_RESULT; k++) begin
              if (CNT_W'(k) == cnt_r) begin
                acc_nxt[k] = ev.data;
              end
            end
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        pbe_pkg::EV_CLOSE: begin
          if (cnt_r != '0) begin
            oval_nxt = 1'b1;
            opk_nxt  = word_flat;
            ocnt_nxt = 3'(cnt_r);
            orow_nxt = ev.row;
            oend_nxt = 1'b0;
            otot_nxt = '0;
            cnt_nxt  = '0;
          end
        end
        pbe_pkg::EV_MARK: begin
          oval_nxt  = 1'b1;
          opk_nxt   = {24'd0, ev.data};
          ocnt_nxt  = 3'd1;
          orow_nxt  = 1'b0;
          oend_nxt  = 1'b1;
          otot_nxt  = total_inc;
          total_nxt = '0;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      total_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    opk_r  <= opk_nxt;
    ocnt_r <= ocnt_nxt;
    orow_r <= orow_nxt;
    oend_r <= oend_nxt;
    otot_r <= otot_nxt;
  end

  assign out_valid  = oval_r;
  assign out_packed = opk_r;
  assign out_count  = ocnt_r;
  assign out_row    = orow_r;
  assign out_end    = oend_r;
  assign out_total  = otot_r;

  a_mark_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ev.valid && ev.kind == pbe_pkg::EV_MARK |-> cnt_r == '0)
    else $error("end marker while a word is still being gathered");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BYTES_PER_RESULT))
    else $error("gather count beyond the result width");

endmodule

// ===== hdl/packbits_row_encoder.sv =====
// Top level of the run-length (PackBits) row encoder.
`timescale 1ns / 1ps

// Usage: row bytes enter on the in_ stream, one request per byte, with tlast on
// the last byte of each row and tuser = 0. A request with tuser = 1 ends the
// stream; send it only between rows. Runs of 3 to 128 equal bytes become a
// two-byte token, other bytes are gathered into literals of at most 128 bytes.
// The out_ stream carries words of up to BYTES_PER_RESULT encoded bytes; tlast
// marks the last word caused by a row's last byte, and tuser marks the single
// end-marker word (byte 128) whose tdata also carries the saturating total of
// encoded bytes in the stream, marker included. The total then restarts at 0.
// Items are handled one at a time, and every encoded byte makes an item take
// longer, because the sequencer walks the tokens one byte per cycle while the
// packer accepts them and dumps a literal from the single read port of the
// 128-entry literal memory. A stalled receiver stops the walk once the output
// register is full and the next event needs it: a byte for a full gather word,
// the close of a non-empty word, or the end marker; nothing is lost.
// Reset returns the sequencer to idle with no run, no pending literal and a zero
// total. The literal memory needs no clearing: only written entries are read.
module packbits_row_encoder #(
  parameter int BYTES_PER_RESULT = pbe_pkg::BYTES_PER_RESULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // row_end
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] packed_bytes, [34:32] byte_count,
                                  // [66:35] encoded_total, [71:67] zero
  output logic        out_tlast,  // row_done
  output logic        out_tuser   // stream_end
);

  pbe_pkg::pbe_ev_t ev;
  logic             ev_ready;

  logic                       lit_wr_en;
  logic [pbe_pkg::LIT_AW-1:0] lit_wr_addr;
  logic [7:0]                 lit_wr_data;
  logic [pbe_pkg::LIT_AW-1:0] lit_rd_addr;
  logic [7:0]                 lit_rd_data;

  logic [31:0] out_packed;
  logic [2:0]  out_count;
  logic [31:0] out_total;

  // Pending literal bytes live in this memory; the sequencer writes them as
  // short runs break and reads them back in order when the literal closes.
  pbe_ram #(
    .WIDTH (8),
    .DEPTH (pbe_pkg::LIT_DEPTH)
  ) u_lit_ram (
    .clk     (clk),
    .wr_en   (lit_wr_en),
    .wr_addr (lit_wr_addr),
    .wr_data (lit_wr_data),
    .rd_addr (lit_rd_addr),
    .rd_data (lit_rd_data)
  );

  pbe_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (in_tuser),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .ev          (ev),
    .ev_ready    (ev_ready),
    .lit_wr_en   (lit_wr_en),
    .lit_wr_addr (lit_wr_addr),
    .lit_wr_data (lit_wr_data),
    .lit_rd_addr (lit_rd_addr),
    .lit_rd_data (lit_rd_data)
  );

  // The packer owns the output register, so the sequencer keeps going while a
  // finished word waits for the receiver.
  pbe_pack #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev         (ev),
    .ev_ready   (ev_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_packed (out_packed),
    .out_count  (out_count),
    .out_row    (out_tlast),
    .out_end    (out_tuser),
    .out_total  (out_total)
  );

  assign out_tdata = {5'd0, out_total, out_count, out_packed};

endmodule
